FILE: hw/rtl/dstf_pkg.sv
package dstf_pkg;

  // Sizes of the parse
  localparam int FRACTION_DIGITS = 10;
  localparam int INTEGER_BITS    = 31;
  localparam int CHAR_W          = 16;
  localparam int DIGIT_W         = 4;
  localparam int POS_W           = 4;
  localparam int FRAC_W          = 32;
  localparam int VALUE_W         = 64;
  localparam int INT_WIDE_W      = INTEGER_BITS + 4;

  localparam logic [POS_W-1:0]        FRAC_LIMIT = POS_W'(FRACTION_DIGITS);
  localparam logic [INTEGER_BITS-1:0] INT_LIMIT  = '1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;

  // Running parse state
  typedef struct packed {
    logic                    negative;
    logic                    in_fraction;
    logic                    finished;
    logic                    overflowed;
    logic [INTEGER_BITS-1:0] integer_acc;
    logic [FRAC_W-1:0]       fraction_acc;
    logic [POS_W-1:0]        digit_pos;
  } parse_state_t;

  // Result of one character step
  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] value;
    logic               saturated;
  } result_t;

  // floor(2^32 / 10^(pos+1))
  function automatic logic [FRAC_W-1:0] pow10_inv(input logic [POS_W-1:0] pos);
    case (pos)
      4'd0:    return 32'd429496729;
      4'd1:    return 32'd42949672;
      4'd2:    return 32'd4294967;
      4'd3:    return 32'd429496;
      4'd4:    return 32'd42949;
      4'd5:    return 32'd4294;
      4'd6:    return 32'd429;
      4'd7:    return 32'd42;
      4'd8:    return 32'd4;
      default: return '0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/decimal_string_to_fixed.sv
// Streaming decimal text to signed Q31.32. One character request is taken per
// cycle while in_stall is low: each accepted character is held in an input
// register and from there goes through the per-character update (integer
// multiply-by-ten add or one fraction table term) into the parse state; a
// terminating character then loads the result register, which presents the
// result. A string that starts with first=1 and ends with a
// non-numeric character (0, a second dot, a late minus, anything else)
// yields one value; the integer part clamps at 2^31-1 and sets saturated,
// fraction digits past the tenth are dropped and table terms are truncated.
// While a result waits on out_stall, characters that produce no result keep
// flowing; the next terminating character waits in the input register and
// holds off further requests until the result register is taken.
module decimal_string_to_fixed (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dstf_pkg::CHAR_W-1:0]         ch,
  input  logic                                first,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dstf_pkg::VALUE_W-1:0] value,
  output logic                                saturated
);

  logic                          s1_valid;
  logic [dstf_pkg::CHAR_W-1:0]   s1_ch;
  logic                          s1_first;
  logic                          s1_go;
  logic                          in_take;
  logic                          out_free;
  logic [dstf_pkg::VALUE_W-1:0]  out_value;
  dstf_pkg::parse_state_t        state;
  dstf_pkg::parse_state_t        state_next;
  dstf_pkg::result_t             res;

  // Held character proceeds unless its result has nowhere to go
  assign s1_go    = s1_valid && (!res.emit || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch    <= ch;
      s1_first <= first;
    end
  end

  // Per-character update
  dstf_step u_step (
    .cur   (state),
    .ch    (s1_ch),
    .first (s1_first),
    .nxt   (state_next),
    .res   (res)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{negative: 1'b0, in_fraction: 1'b0, finished: 1'b1, overflowed: 1'b0,
                 integer_acc: '0, fraction_acc: '0, digit_pos: '0};
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  // Result register
  dstf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go && res.emit),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (out_value),
    .saturated (saturated)
  );

  assign value = $signed(out_value);

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(s1_go && res.emit))
    else $error("result register overwritten while stalled");

  // Fraction digit count stays within the table
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state.digit_pos <= dstf_pkg::FRAC_LIMIT)
    else $error("fraction digit count out of range");

  // No fraction before the dot
  a_frac_mode: assert property (@(posedge clk) disable iff (rst)
    !state.in_fraction |-> (state.digit_pos == '0 && state.fraction_acc == '0))
    else $error("fraction state outside fraction mode");

  // Emitting ends the parse and presents the result
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res.emit) |=> (state.finished && out_valid))
    else $error("emit did not finish parse");

endmodule

FILE: hw/rtl/dstf_step.sv
module dstf_step (
  input  dstf_pkg::parse_state_t        cur,
  input  logic [dstf_pkg::CHAR_W-1:0]   ch,
  input  logic                          first,
  output dstf_pkg::parse_state_t        nxt,
  output dstf_pkg::result_t             res
);

  dstf_pkg::parse_state_t               base;
  logic [dstf_pkg::CHAR_W-1:0]          digit_full;
  logic [dstf_pkg::DIGIT_W-1:0]         digit;
  logic                                 is_digit;
  logic [dstf_pkg::INT_WIDE_W-1:0]      int_base;
  logic [dstf_pkg::INT_WIDE_W-1:0]      int_wide;
  logic                                 int_over;
  logic [dstf_pkg::FRAC_W+3:0]          frac_term;
  logic [dstf_pkg::VALUE_W-1:0]         mag;

  // A first character drops any parse in progress
  always_comb begin
    base = cur;
    if (first) begin
      base = '0;
    end
  end

  // Digit decode
  assign digit_full = ch - dstf_pkg::CH_ZERO;
  assign digit      = digit_full[dstf_pkg::DIGIT_W-1:0];
  assign is_digit   = (ch >= dstf_pkg::CH_ZERO) && (ch <= dstf_pkg::CH_NINE);

  // Integer part: acc * 10 + digit, as shift-add
  assign int_base = {4'b0, base.integer_acc};
  assign int_wide = (int_base << 3) + (int_base << 1)
                  + {{(dstf_pkg::INT_WIDE_W-dstf_pkg::DIGIT_W){1'b0}}, digit};
  assign int_over = int_wide > {4'b0, dstf_pkg::INT_LIMIT};

  // Fraction term: digit times tabled 10^-k
  assign frac_term = {{dstf_pkg::FRAC_W{1'b0}}, digit}
                   * {4'b0, dstf_pkg::pow10_inv(base.digit_pos)};

  // Magnitude of the finished number
  assign mag = {{(dstf_pkg::FRAC_W-dstf_pkg::INTEGER_BITS){1'b0}},
                base.integer_acc, base.fraction_acc};

  // Character decision
  always_comb begin
    nxt = base;
    res = '0;
    if (first && ch == dstf_pkg::CH_MINUS) begin
      nxt.negative = 1'b1;
    end else if (!first && cur.finished) begin
      nxt = cur;
    end else if (is_digit) begin
      if (base.in_fraction) begin
        if (base.digit_pos < dstf_pkg::FRAC_LIMIT) begin
          nxt.fraction_acc = base.fraction_acc + frac_term[dstf_pkg::FRAC_W-1:0];
          nxt.digit_pos    = base.digit_pos + 1'b1;
        end
      end else if (int_over) begin
        nxt.integer_acc = dstf_pkg::INT_LIMIT;
        nxt.overflowed  = 1'b1;
      end else begin
        nxt.integer_acc = int_wide[dstf_pkg::INTEGER_BITS-1:0];
      end
    end else if (ch == dstf_pkg::CH_DOT && !base.in_fraction) begin
      nxt.in_fraction = 1'b1;
    end else begin
      res.emit      = 1'b1;
      res.saturated = base.overflowed;
      res.value     = base.negative ? (~mag + 64'd1) : mag;
      nxt.finished  = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/dstf_out_reg.sv
module dstf_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  dstf_pkg::result_t              res,
  output logic                           free,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dstf_pkg::VALUE_W-1:0]   value,
  output logic                           saturated
);

  // Room for a new result when empty or being taken
  assign free = !out_valid || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      value     <= res.value;
      saturated <= res.saturated;
    end
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import dstf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEM_GOAL    = 850;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS     = 25;

  localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_FIVE   = 16'h0035;
  localparam logic [CHAR_W-1:0] CH_SEVEN  = 16'h0037;
  localparam logic [CHAR_W-1:0] CH_LETTER = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_TOP    = 16'hFFFF;

  // floor(2^32 / 10^k) for fraction digit k = 1 .. 12
  localparam logic [FRAC_W-1:0] TENTH_STEP [12] = '{
    32'd429496729, 32'd42949672, 32'd4294967, 32'd429496, 32'd42949, 32'd4294,
    32'd429, 32'd42, 32'd4, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sat;
  } fixed_res_t;

  typedef struct packed {
    logic                    neg;
    logic                    frac_mode;
    logic                    done;
    logic                    clamped;
    logic [INTEGER_BITS-1:0] whole;
    logic [FRAC_W-1:0]       part;
    logic [POS_W-1:0]        frac_cnt;
  } scan_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  c;
    logic               lead;
    logic               typed;
    logic [VALUE_W-1:0] value;
    logic               sat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [CHAR_W-1:0] ch;
  logic first;
  logic out_valid;
  logic out_stall;
  logic signed [VALUE_W-1:0] value;
  logic saturated;

  scan_t      scan;
  fixed_res_t pending_q[$];
  dir_row_t   dir_rows [DIR_ROWS];
  int         taken;
  int         errors;
  int         cycles;
  logic       calm;

  decimal_string_to_fixed dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .first     (first),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .saturated (saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parse one character into the running scan; returns 1 when a value comes out
  function automatic logic scan_char(input logic [CHAR_W-1:0] c, input logic lead,
                                     output fixed_res_t res);
    longint unsigned grown;
    longint unsigned cap;
    logic [VALUE_W-1:0] mag;
    cap = (64'd1 << INTEGER_BITS) - 64'd1;
    res = '0;
    if (lead) begin
      scan = '0;
      if (c == CH_MINUS) begin
        scan.neg = 1'b1;
        return 1'b0;
      end
    end else if (scan.done) begin
      return 1'b0;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (scan.frac_mode) begin
        // digits past FRACTION_DIGITS are swallowed
        if (scan.frac_cnt < FRACTION_DIGITS && scan.frac_cnt < 12) begin
          scan.part += FRAC_W'(c - CH_ZERO) * TENTH_STEP[scan.frac_cnt];
          scan.frac_cnt++;
        end
      end else begin
        grown = 64'(scan.whole) * 64'd10 + 64'(c - CH_ZERO);
        if (grown > cap) begin
          grown = cap;
          scan.clamped = 1'b1;
        end
        scan.whole = INTEGER_BITS'(grown);
      end
      return 1'b0;
    end
    if (c == CH_DOT && !scan.frac_mode) begin
      scan.frac_mode = 1'b1;
      return 1'b0;
    end
    mag = VALUE_W'({scan.whole, scan.part});
    res.value = scan.neg ? -mag : mag;
    res.sat = scan.clamped;
    scan.done = 1'b1;
    return 1'b1;
  endfunction

  // Append one expected value at the tail of the pending list
  function automatic void queue_expected(input fixed_res_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  // Present one character request, wait for it to be taken, then predict
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic lead,
                           input logic typed, input fixed_res_t typed_res);
    fixed_res_t res;
    logic makes;
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    first <= lead;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    makes = scan_char(c, lead, res);
    if (typed) queue_expected(typed_res);
    else if (makes) queue_expected(res);
    taken++;
  endtask

  // Hold the sender until every pending value has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 36);
  end

  // Result checker
  always @(posedge clk) begin
    fixed_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %h saturated %0b", value, saturated);
      end else begin
        want = pending_q.pop_front();
        if (value !== want.value || saturated !== want.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: value exp %h got %h, saturated exp %0b got %0b",
                     want.value, value, want.sat, saturated);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("decimal_string_to_fixed test failed");
      $finish;
    end
  end

  initial begin
    logic lead;
    logic paused;
    int pick;
    int n_int;
    int n_frac;
    logic [CHAR_W-1:0] tail;

    rst <= 1'b1;
    in_valid <= 1'b0;
    ch <= '0;
    first <= 1'b0;
    out_stall <= 1'b0;
    taken = 0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    paused = 1'b0;
    scan = '0;
    scan.done = 1'b1;

    dir_rows = '{
      // idle character right after reset
      '{CH_LETTER, 1'b0, 1'b0, 64'd0, 1'b0},
      // empty string
      '{CH_NUL,    1'b1, 1'b1, 64'd0, 1'b0},
      // minus in a later position ends the parse
      '{CH_MINUS,  1'b1, 1'b0, 64'd0, 1'b0},
      '{CH_MINUS,  1'b0, 1'b1, 64'd0, 1'b0},
      // second dot ends the parse
      '{CH_DOT,    1'b1, 1'b0, 64'd0, 1'b0},
      '{CH_DOT,    1'b0, 1'b1, 64'd0, 1'b0},
      // restart abandons "7", then ".5"
      '{CH_SEVEN,  1'b1, 1'b0, 64'd0, 1'b0},
      '{CH_DOT,    1'b1, 1'b0, 64'd0, 1'b0},
      '{CH_FIVE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NUL,    1'b0, 1'b0, 64'd0, 1'b0},
      // ignored after the end
      '{CH_LETTER, 1'b0, 1'b0, 64'd0, 1'b0},
      // "-9999999999.0" clamps the integer part
      '{CH_MINUS,  1'b1, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_DOT,    1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,   1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_TOP,    1'b0, 1'b1, 64'h8000_0001_0000_0000, 1'b1}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_char(dir_rows[i].c, dir_rows[i].lead, dir_rows[i].typed,
                '{dir_rows[i].value, dir_rows[i].sat});

    // Random strings, mostly well formed, with some noise
    while (taken < ITEM_GOAL) begin
      calm = (taken >= 300 && taken < 420);
      if (!paused && taken >= 550) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 78) begin
        lead = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          send_char(CH_MINUS, lead, 1'b0, '0);
          lead = 1'b0;
        end
        n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
        repeat (n_int) begin
          send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)), lead, 1'b0, '0);
          lead = 1'b0;
        end
        if ($urandom_range(0, 9) < 7) begin
          send_char(CH_DOT, lead, 1'b0, '0);
          lead = 1'b0;
          n_frac = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
          repeat (n_frac)
            send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0, 1'b0, '0);
        end
        pick = $urandom_range(0, 99);
        // a few strings are left open so the next one restarts over them
        if (pick >= 8) begin
          if (pick < 60) tail = CH_NUL;
          else if (pick < 70) tail = CH_MINUS;
          else if (pick < 78) tail = CH_DOT;
          else tail = CHAR_W'($urandom_range(0, 65535));
          send_char(tail, lead, 1'b0, '0);
          repeat ($urandom_range(0, 2))
            send_char(CHAR_W'($urandom_range(0, 65535)), 1'b0, 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 5))
          send_char(CHAR_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0, 1'b0, '0);
      end
    end

    calm = 1'b0;
    drain();
    if (errors == 0)
      $display("decimal_string_to_fixed test passed");
    else
      $display("decimal_string_to_fixed test failed");
    $finish;
  end

endmodule
